### design/mtc_pkg.sv
// mtc_pkg: shared constants and types for the Markov transition counter.
// Used by mtc_divider and markov_transition_counter; depends on nothing.
package mtc_pkg;

  localparam int MAX_STATES_DEF  = 64;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int STATE_IN_W      = 6;
  localparam int CFG_W           = 7;
  localparam logic [CFG_W-1:0] STATES_RESET = 7'd64;

  localparam int FRAC_W          = 16;
  localparam int PROB_W          = FRAC_W + 1;
  localparam int PCOUNT_W        = 32;

  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 56;

  localparam logic FUNC_RECORD   = 1'b0;
  localparam logic FUNC_QUERY    = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### design/mtc_ram.sv
// mtc_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/mtc_divider.sv
// mtc_divider: restoring divider, one quotient bit per cycle.
// Returns floor(num * 2^16 / den) for num <= den. Depends on mtc_pkg.
module mtc_divider #(
  parameter int COUNT_BITS = mtc_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [COUNT_BITS-1:0]       num,
  input  logic [COUNT_BITS-1:0]       den,
  output mtc_pkg::div_status_t        st,
  output logic [mtc_pkg::PROB_W-1:0]  quot
);

  localparam int STEP_W = $clog2(mtc_pkg::PROB_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mtc_pkg::PROB_W - 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [COUNT_BITS:0]         rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]       den_r, den_nxt;
  logic [mtc_pkg::PROB_W-1:0]  q_r, q_nxt;

  logic                        ge;
  logic [COUNT_BITS:0]         diff;
  logic [COUNT_BITS:0]         part;

  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    diff     = rem_r - {1'b0, den_r};
    part     = ge ? diff : rem_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = {part[COUNT_BITS-1:0], 1'b0};
      q_nxt    = {q_r[mtc_pkg::PROB_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quot    = q_r;

endmodule

### design/markov_transition_counter.sv
// markov_transition_counter: transition counts and Q1.16 probabilities per state pair.
// Depends on mtc_pkg, mtc_ram (count, row sum, seen stores) and mtc_divider.
//
//  channel | ports                 | contents
//  --------+-----------------------+------------------------------------------------
//  in      | in_tvalid/tready      | tuser: func; tdata: from_state, to_state
//  out     | out_tvalid/tready     | tdata: pair_count, probability_q16, seen, ovf
//  cfg     | cfg_wr_en/cfg_wr_data | states_in_use
//
// After reset a clearing pass over all MAX_STATES*MAX_STATES cells zeroes all stores;
// in_tready stays low until it ends. Config writes are taken at any time.
// Each item steps through S_ADDR, S_RD1-S_RD3, S_UPD1, S_UPD2, S_DIVGO, the 17-step
// shared divider in S_DIVW, and S_OUT; S_DIVW is skipped when the source was seen but the target never was.
// One item at a time.
// A stalled result holds in the output register while the next item is accepted.
module markov_transition_counter #(
  parameter int MAX_STATES = mtc_pkg::MAX_STATES_DEF,
  parameter int COUNT_BITS = mtc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mtc_pkg::IN_TDATA_W-1:0]   in_tdata,  // from_state, to_state
  input  logic                             in_tuser,  // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pair_count, probability_q16, source_seen, target_seen, overflow_flag
  output logic [mtc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [mtc_pkg::CFG_W-1:0]        cfg_wr_data
);

  localparam int IDXW  = $clog2(MAX_STATES);
  localparam int CELLS = MAX_STATES * MAX_STATES;
  localparam int CW    = $clog2(CELLS);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
  localparam int PW = mtc_pkg::PROB_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_RD3   = 4'd5;
  localparam logic [3:0] S_UPD1  = 4'd6;
  localparam logic [3:0] S_UPD2  = 4'd7;
  localparam logic [3:0] S_DIVGO = 4'd8;
  localparam logic [3:0] S_DIVW  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  function automatic logic [IDXW-1:0] reduce_idx(input logic [mtc_pkg::STATE_IN_W-1:0] v);
    logic [IDXW:0] rem;
    int i;
    rem = '0;
    for (i = mtc_pkg::STATE_IN_W - 1; i >= 0; i--) begin
      rem = {rem[IDXW-1:0], v[i]};
      if (rem >= (IDXW+1)'(MAX_STATES)) begin
        rem = rem - (IDXW+1)'(MAX_STATES);
      end
    end
    return rem[IDXW-1:0];
  endfunction

  logic [3:0]                 state_r, state_nxt;
  logic [CW-1:0]              clr_r, clr_nxt;
  logic [mtc_pkg::CFG_W-1:0]  states_r;
  logic [IDXW-1:0]            f_r, f_nxt, t_r, t_nxt;
  logic                       func_r, func_nxt;
  logic [CW-1:0]              cell_r, cell_nxt;
  logic [COUNT_BITS-1:0]      cnt_r, cnt_nxt, sum_r, sum_nxt;
  logic                       sf_r, sf_nxt, tf_r, tf_nxt, ovf_r, ovf_nxt;
  logic [PW-1:0]              prob_r, prob_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [mtc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                       pc_we, row_we, seen_we;
  logic [CW-1:0]              pc_waddr, pc_raddr;
  logic [IDXW-1:0]            row_waddr, row_raddr, seen_waddr, seen_raddr;
  logic [COUNT_BITS-1:0]      pc_wdata, row_wdata, pc_rdata, row_rdata;
  logic                       seen_wdata, seen_rdata;

  logic                       div_start;
  logic [COUNT_BITS-1:0]      div_num, div_den, n_eff;
  logic [PW-1:0]              div_quot;
  mtc_pkg::div_status_t       div_st;
  logic                       do_update, use_uniform;

  mtc_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_pair_ram (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .raddr(pc_raddr), .rdata(pc_rdata)
  );

  mtc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_STATES)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  mtc_ram #(.WIDTH(1), .DEPTH(MAX_STATES)) u_seen_ram (
    .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
    .raddr(seen_raddr), .rdata(seen_rdata)
  );

  mtc_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .st(div_st), .quot(div_quot)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign do_update   = (func_r == mtc_pkg::FUNC_RECORD) && !ovf_r;
  assign n_eff       = (states_r == '0) ? COUNT_BITS'(1) : COUNT_BITS'(states_r);
  assign use_uniform = !sf_r || (sum_r == '0);
  assign div_num     = use_uniform ? COUNT_BITS'(1) : cnt_r;
  assign div_den     = use_uniform ? n_eff : sum_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    f_nxt         = f_r;
    t_nxt         = t_r;
    func_nxt      = func_r;
    cell_nxt      = cell_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    sf_nxt        = sf_r;
    tf_nxt        = tf_r;
    ovf_nxt       = ovf_r;
    prob_nxt      = prob_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    pc_we         = 1'b0;
    pc_waddr      = cell_r;
    pc_wdata      = cnt_r + COUNT_BITS'(1);
    pc_raddr      = cell_r;
    row_we        = 1'b0;
    row_waddr     = f_r;
    row_wdata     = sum_r + COUNT_BITS'(1);
    row_raddr     = f_r;
    seen_we       = 1'b0;
    seen_waddr    = f_r;
    seen_wdata    = 1'b1;
    seen_raddr    = f_r;
    unique case (state_r)
      S_CLEAR: begin
        pc_we      = 1'b1;
        pc_waddr   = clr_r;
        pc_wdata   = '0;
        row_waddr  = clr_r[IDXW-1:0];
        row_wdata  = '0;
        seen_waddr = clr_r[IDXW-1:0];
        seen_wdata = 1'b0;
        if (clr_r < CW'(MAX_STATES)) begin
          row_we  = 1'b1;
          seen_we = 1'b1;
        end
        clr_nxt = clr_r + CW'(1);
        if (clr_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          f_nxt     = reduce_idx(in_tdata[5:0]);
          t_nxt     = reduce_idx(in_tdata[11:6]);
          func_nxt  = in_tuser;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cell_nxt  = CW'(f_r) * CW'(MAX_STATES) + CW'(t_r);
        state_nxt = S_RD1;
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cnt_nxt    = pc_rdata;
        sum_nxt    = row_rdata;
        sf_nxt     = seen_rdata;
        seen_raddr = t_r;
        state_nxt  = S_RD3;
      end
      S_RD3: begin
        tf_nxt    = seen_rdata;
        ovf_nxt   = (func_r == mtc_pkg::FUNC_RECORD) && ((cnt_r == CMAX) || (sum_r == CMAX));
        state_nxt = S_UPD1;
      end
      S_UPD1: begin
        if (do_update) begin
          pc_we   = 1'b1;
          row_we  = 1'b1;
          seen_we = 1'b1;
          cnt_nxt = cnt_r + COUNT_BITS'(1);
          sum_nxt = sum_r + COUNT_BITS'(1);
          sf_nxt  = 1'b1;
          tf_nxt  = 1'b1;
        end
        state_nxt = S_UPD2;
      end
      S_UPD2: begin
        seen_waddr = t_r;
        seen_we    = do_update;
        state_nxt  = S_DIVGO;
      end
      S_DIVGO: begin
        if (sf_r && !tf_r) begin
          prob_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_st.done) begin
          prob_nxt  = div_quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, ovf_r, tf_r, sf_r, prob_r, mtc_pkg::PCOUNT_W'(cnt_r)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      states_r    <= mtc_pkg::STATES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        states_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    f_r        <= f_nxt;
    t_r        <= t_nxt;
    func_r     <= func_nxt;
    cell_r     <= cell_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    sf_r       <= sf_nxt;
    tf_r       <= tf_nxt;
    ovf_r      <= ovf_nxt;
    prob_r     <= prob_nxt;
    out_data_r <= out_data_nxt;
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while another is in progress");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[48:32] <= 17'd65536)
    else $error("probability above 1.0");

  a_unseen_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49] && !out_tdata[50] |-> out_tdata[48:32] == '0)
    else $error("nonzero probability toward an unseen state");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_st.busy)
    else $error("divider busy while sequencer idle");

endmodule

### tb/markov_transition_counter_test.sv
// markov_transition_counter_test: self-checking bench for markov_transition_counter.
// It predicts every result from its own count tables and checks each out item field by field.
// It depends on mtc_pkg and the markov_transition_counter RTL only.
module markov_transition_counter_test;
  import mtc_pkg::*;

  typedef struct packed {
    logic       func;
    logic [5:0] from_state;
    logic [5:0] to_state;
  } transition_t;

  typedef struct packed {
    logic [31:0] pair_count;
    logic [16:0] prob;
    logic        src_seen;
    logic        dst_seen;
    logic        ovf;
  } estimate_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // from_state, to_state
  logic                   in_tuser = 1'b0; // func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // pair_count, probability_q16, src, dst, ovf
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  markov_transition_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [31:0]      pair_tally [0:4095];
  logic [31:0]      row_tally [0:63];
  logic             state_seen [0:63];
  logic [CFG_W-1:0] states_cfg;

  transition_t queued_transitions [$];
  estimate_t   awaited_estimates [$];
  transition_t current_item;
  int          mismatch_count = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  bit          gaps_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("markov_transition_counter_test failed");
    $finish;
  end

  function automatic logic [16:0] uniform_q16();
    logic [31:0] n;
    n = (states_cfg == 0) ? 32'd1 : 32'(states_cfg);
    return 17'(32'd65536 / n);
  endfunction

  function automatic estimate_t tally_transition(transition_t it);
    estimate_t   r;
    int          idx;
    logic [63:0] scaled;
    idx = {it.from_state, it.to_state};
    r.ovf = 1'b0;
    if (it.func == FUNC_RECORD) begin
      if (pair_tally[idx] == 32'hFFFF_FFFF || row_tally[it.from_state] == 32'hFFFF_FFFF) begin
        r.ovf = 1'b1;
      end else begin
        pair_tally[idx]++;
        row_tally[it.from_state]++;
        state_seen[it.from_state] = 1'b1;
        state_seen[it.to_state] = 1'b1;
      end
    end
    r.pair_count = pair_tally[idx];
    r.src_seen = state_seen[it.from_state];
    r.dst_seen = state_seen[it.to_state];
    if (!r.src_seen) r.prob = uniform_q16();
    else if (!r.dst_seen) r.prob = '0;
    else if (row_tally[it.from_state] == 0) r.prob = uniform_q16();
    else begin
      scaled = ({32'b0, pair_tally[idx]} << 16) / {32'b0, row_tally[it.from_state]};
      r.prob = scaled[16:0];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic check_estimate(input logic [OUT_TDATA_W-1:0] td);
    estimate_t got;
    estimate_t want;
    got.pair_count = td[31:0];
    got.prob = td[48:32];
    got.src_seen = td[49];
    got.dst_seen = td[50];
    got.ovf = td[51];
    if (awaited_estimates.size() == 0) begin
      report_mismatch("unexpected out item", td, 0);
      return;
    end
    want = awaited_estimates.pop_front();
    if (got.pair_count != want.pair_count)
      report_mismatch("pair_count", got.pair_count, want.pair_count);
    if (got.prob != want.prob) report_mismatch("probability_q16", got.prob, want.prob);
    if (got.src_seen != want.src_seen)
      report_mismatch("source_seen", got.src_seen, want.src_seen);
    if (got.dst_seen != want.dst_seen)
      report_mismatch("target_seen", got.dst_seen, want.dst_seen);
    if (got.ovf != want.ovf) report_mismatch("overflow_flag", got.ovf, want.ovf);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) awaited_estimates.push_back(tally_transition(current_item));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (queued_transitions.size() > 0) begin
          current_item = queued_transitions.pop_front();
          in_tdata <= {4'b0, current_item.to_state, current_item.from_state};
          in_tuser <= current_item.func;
          in_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) check_estimate(out_tdata);
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap();
      end
    end
  end

  task automatic queue_item(input logic func, input int from_state, input int to_state);
    transition_t it;
    it.func = func;
    it.from_state = 6'(from_state);
    it.to_state = 6'(to_state);
    queued_transitions.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_transitions.size() != 0 || in_tvalid || awaited_estimates.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_states(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    states_cfg = value;
  endtask

  // records stay mostly inside an 8-state cluster so rows build up real counts
  task automatic queue_random_phase(input int base, input int n_items);
    int f;
    int t;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 55) : base + $urandom_range(0, 7);
        t = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 55) : base + $urandom_range(0, 7);
        queue_item(FUNC_RECORD, f, t);
      end else if ($urandom_range(0, 9) < 7) begin
        queue_item(FUNC_QUERY, base + $urandom_range(0, 7), base + $urandom_range(0, 7));
      end else begin
        queue_item(FUNC_QUERY, $urandom_range(0, 63), $urandom_range(0, 63));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg [0:6];
    for (int i = 0; i < 4096; i++) pair_tally[i] = '0;
    for (int i = 0; i < 64; i++) begin
      row_tally[i] = '0;
      state_seen[i] = 1'b0;
    end
    states_cfg = STATES_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: unseen source, unseen target, seen-only-as-target row, fractions
    queue_item(FUNC_QUERY, 0, 0);
    queue_item(FUNC_QUERY, 63, 63);
    queue_item(FUNC_RECORD, 0, 0);
    queue_item(FUNC_QUERY, 0, 0);
    queue_item(FUNC_QUERY, 0, 5);
    queue_item(FUNC_RECORD, 0, 63);
    queue_item(FUNC_RECORD, 63, 0);
    queue_item(FUNC_QUERY, 0, 63);
    queue_item(FUNC_QUERY, 63, 63);
    queue_item(FUNC_QUERY, 5, 0);
    queue_item(FUNC_RECORD, 63, 63);
    queue_item(FUNC_QUERY, 63, 0);
    queue_item(FUNC_RECORD, 10, 20);
    queue_item(FUNC_QUERY, 20, 10);
    queue_item(FUNC_RECORD, 21, 42);
    queue_item(FUNC_RECORD, 42, 21);
    queue_item(FUNC_QUERY, 42, 42);
    for (int i = 0; i < 3; i++) queue_item(FUNC_RECORD, 1, 2);
    queue_item(FUNC_RECORD, 1, 3);
    queue_item(FUNC_QUERY, 1, 2);
    queue_item(FUNC_RECORD, 1, 4);
    queue_item(FUNC_QUERY, 1, 3);
    queue_item(FUNC_QUERY, 1, 4);
    wait_drained();

    phase_cfg[0] = 7'd1;
    phase_cfg[1] = 7'd0;
    phase_cfg[2] = 7'd127;
    phase_cfg[3] = 7'd65;
    phase_cfg[4] = 7'd64;
    phase_cfg[5] = 7'($urandom_range(1, 127));
    phase_cfg[6] = 7'($urandom_range(1, 127));
    for (int p = 0; p < 7; p++) begin
      write_states(phase_cfg[p]);
      gaps_on = (p != 3);
      @(negedge clk);
      queue_random_phase((p * 8) % 56, 160);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("markov_transition_counter_test passed");
    end else begin
      $display("markov_transition_counter_test failed");
    end
    $finish;
  end

endmodule
